// File: src/fkil_pkg.sv
// Shared types, constants and codes for the keyed index lookup block.
// No dependencies; every other file in src except fkil_ram imports this package.
package fkil_pkg;

	// Index capacity and entry geometry
	localparam int MAX_ENTRIES = 64;
	localparam int ENTRY_BYTES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	// Field widths
	localparam int CMD_W = 2;
	localparam int SLOT_W = 6;
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;
	localparam int STATUS_W = 3;
	localparam int ECNT_W = 7;

	// Stream payload widths, rounded up to whole bytes
	localparam int S_TDATA_W = 144;
	localparam int M_TDATA_W = 104;

	// Lookup request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// FNV-1a 32-bit constants
	localparam logic [WORD_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [WORD_W-1:0] FNV_PRIME = 32'd16777619;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_KEY    = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_MISS      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_INDEX_OOB = 3'd3,
		ST_DATA_OOB  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_STORE_VALID = 2'd0,
		REG_ENTRY_COUNT = 2'd1,
		REG_INDEX_START = 2'd2,
		REG_STORE_BYTES = 2'd3
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic              store_valid;
		logic [ECNT_W-1:0] entry_count;
		logic [WORD_W-1:0] index_start;
		logic [WORD_W-1:0] store_bytes;
	} cfg_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] slot_hash;
		logic [WORD_W-1:0] slot_offset;
		logic [WORD_W-1:0] slot_size;
		logic [BYTE_W-1:0] key_byte;
		logic [WORD_W-1:0] method_code;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] size;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] hash;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		entry_t             data;
	} ram_wr_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] hit_slot;
		logic [WORD_W-1:0] data_offset;
		logic [WORD_W-1:0] data_size;
		logic [WORD_W-1:0] key_hash;
	} result_t;

endpackage

// File: src/fnv_keyed_index_lookup.sv
// Top level of the keyed index lookup block: stream ports, APB registers,
// front, lookup queue, back and index RAM. Depends on fkil_pkg and all fkil_ modules.
//
// Usage:
//   s_* carries commands (s_tuser): write index entry, key byte, end key and
//   look up. Key bytes are hashed at one per cycle with FNV-1a. Entry writes
//   stall (s_tready low) until all queued lookups have finished scanning. A
//   lookup folds in the method value and enters a two-deep queue; it
//   produces exactly one result on m_*.
//   A lookup on an empty store or with the index out of bounds is answered
//   without a scan; else the scan stops at the first hit, and a miss scans
//   all min(entry_count, 64) entries, one per cycle through the RAM read port.
//   The result register holds while m_tready is low; the front keeps taking
//   key bytes and queues up to two lookups meanwhile.
//   Reset clears the running hash to the offset basis, the APB registers to 0
//   and the queue; index entries are undefined until written.
//   The user must write registers through APB only while the block is idle;
//   the block itself does not enforce this.
module fnv_keyed_index_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// slot[5:0], slot_hash[37:6], slot_offset[69:38], slot_size[101:70],
	// key_byte[109:102], method_code[141:110], zero pad[143:142]
	input  logic [fkil_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [fkil_pkg::CMD_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit_slot[5:0], data_offset[37:6], data_size[69:38], key_hash[101:70],
	// zero pad[103:102]
	output logic [fkil_pkg::M_TDATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [fkil_pkg::STATUS_W-1:0]  m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import fkil_pkg::*;

	cfg_t              cfg_q;
	in_item_t          item;
	ram_wr_t           wr;
	result_t           result;
	logic              q_push;
	logic [WORD_W-1:0] q_push_key;
	logic              q_pop;
	logic [WORD_W-1:0] q_head;
	logic              q_empty;
	logic              q_full;
	logic              back_busy;
	logic [IDX_W-1:0]  raddr;
	logic [ENTRY_W-1:0] rdata;
	logic              cfg_wr;
	reg_idx_t          reg_sel;

	// Unpack the input item
	always_comb begin
		item.cmd         = cmd_t'(s_tuser);
		item.slot        = s_tdata[5:0];
		item.slot_hash   = s_tdata[37:6];
		item.slot_offset = s_tdata[69:38];
		item.slot_size   = s_tdata[101:70];
		item.key_byte    = s_tdata[109:102];
		item.method_code = s_tdata[141:110];
	end

	// APB register file
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_STORE_VALID: cfg_q.store_valid <= pwdata[0];
				REG_ENTRY_COUNT: cfg_q.entry_count <= pwdata[ECNT_W-1:0];
				REG_INDEX_START: cfg_q.index_start <= pwdata;
				REG_STORE_BYTES: cfg_q.store_bytes <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_STORE_VALID: prdata = {31'b0, cfg_q.store_valid};
			REG_ENTRY_COUNT: prdata = {{(32 - ECNT_W){1'b0}}, cfg_q.entry_count};
			REG_INDEX_START: prdata = cfg_q.index_start;
			REG_STORE_BYTES: prdata = cfg_q.store_bytes;
		endcase
	end

	fkil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.q_full    (q_full),
		.q_empty   (q_empty),
		.back_busy (back_busy),
		.push      (q_push),
		.push_key  (q_push_key),
		.wr        (wr)
	);

	fkil_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_key (q_push_key),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	fkil_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_index_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	fkil_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (q_pop),
		.busy      (back_busy),
		.raddr     (raddr),
		.rdata     (rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	// Pack the result item
	assign m_tuser = result.status;
	assign m_tdata = {2'b0, result.key_hash, result.data_size, result.data_offset,
		result.hit_slot};

endmodule

// File: src/fkil_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module fkil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/fkil_queue.sv
// Short FIFO of lookup key hashes between the front and back parts.
// Depends on fkil_pkg for depth and width constants.
module fkil_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [fkil_pkg::WORD_W-1:0] push_key,
	input  logic                       pop,
	output logic [fkil_pkg::WORD_W-1:0] head,
	output logic                       empty,
	output logic                       full
);
	import fkil_pkg::*;

	logic [WORD_W-1:0] buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = buf_q[rp_q];

	// Store pushed keys
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_key;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: src/fkil_front.sv
// Front part: accepts input items, keeps the running FNV-1a hash, writes
// index entries and queues lookup keys. Depends on fkil_pkg.
module fkil_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  fkil_pkg::in_item_t          item,
	input  logic                        q_full,
	input  logic                        q_empty,
	input  logic                        back_busy,
	output logic                        push,
	output logic [fkil_pkg::WORD_W-1:0] push_key,
	output fkil_pkg::ram_wr_t           wr
);
	import fkil_pkg::*;

	logic [WORD_W-1:0] hash_q;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] prod;
	logic              accept;

	// Fold either the key byte or the method value into the hash
	assign mix  = hash_q ^ ((item.cmd == CMD_KEY) ? {{(WORD_W - BYTE_W){1'b0}}, item.key_byte}
		: item.method_code);
	assign prod = mix * FNV_PRIME;

	// Hold entry writes until every earlier lookup has finished its scan, and lookups while the queue is full
	always_comb begin
		unique case (item.cmd)
			CMD_WRITE:  in_ready = q_empty && !back_busy;
			CMD_LOOKUP: in_ready = !q_full;
			default:    in_ready = 1'b1;
		endcase
	end

	assign accept   = in_valid && in_ready;
	assign push     = accept && (item.cmd == CMD_LOOKUP);
	assign push_key = prod;

	// Index entry write, dropped for slots beyond capacity
	always_comb begin
		wr.en          = accept && (item.cmd == CMD_WRITE)
			&& (32'(item.slot) < 32'(MAX_ENTRIES));
		wr.addr        = IDX_W'(item.slot);
		wr.data.hash   = item.slot_hash;
		wr.data.offset = item.slot_offset;
		wr.data.size   = item.slot_size;
	end

	// Running hash: advance on key bytes, restart after each lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (accept && (item.cmd == CMD_KEY)) begin
			hash_q <= prod;
		end else if (push) begin
			hash_q <= FNV_BASIS;
		end
	end

endmodule

// File: src/fkil_back.sv
// Back part: takes queued lookup keys, checks store bounds, scans the index
// RAM in order and holds the result for the output channel. Depends on fkil_pkg.
module fkil_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fkil_pkg::cfg_t              cfg,
	input  logic                        q_empty,
	input  logic [fkil_pkg::WORD_W-1:0] q_head,
	output logic                        pop,
	output logic                        busy,
	output logic [fkil_pkg::IDX_W-1:0]  raddr,
	input  logic [fkil_pkg::ENTRY_W-1:0] rdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fkil_pkg::result_t           result
);
	import fkil_pkg::*;

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [WORD_W-1:0] key_q;
	logic [CNT_W-1:0]  ra_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              out_valid_q;
	result_t           result_q;

	entry_t            ent;
	logic [CNT_W-1:0]  n_lim;
	logic              out_free;
	logic              start;
	logic              is_empty;
	logic              idx_oob;
	logic              issue;
	logic              hit;
	logic              data_oob;
	logic              last;
	logic              ld;
	result_t           ld_res;

	assign ent      = entry_t'(rdata);
	assign out_free = !out_valid_q || out_ready;
	assign start    = (state_q == BK_IDLE) && !q_empty && out_free;
	assign busy     = (state_q != BK_IDLE);
	assign raddr    = ra_q[IDX_W-1:0];

	// Scan length is the entry count held to capacity
	assign n_lim = (32'(cfg.entry_count) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: CNT_W'(cfg.entry_count);

	// Store and index region bounds
	assign is_empty = !cfg.store_valid || (cfg.entry_count == '0);
	assign idx_oob  = ({1'b0, cfg.index_start} + 33'(cfg.entry_count) * 33'(ENTRY_BYTES))
		> {1'b0, cfg.store_bytes};

	// Entry compare on the registered read data
	assign issue    = (state_q == BK_SCAN) && (ra_q < n_lim);
	assign hit      = vld_s1 && (ent.hash == key_q);
	assign data_oob = ({1'b0, ent.offset} + {1'b0, ent.size}) > {1'b0, cfg.store_bytes};
	assign last     = vld_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == n_lim);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start && !is_empty && !idx_oob) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (hit || last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs: queue pop and result load
	always_comb begin
		pop                = 1'b0;
		ld                 = 1'b0;
		ld_res.status      = ST_MISS;
		ld_res.hit_slot    = '0;
		ld_res.data_offset = '0;
		ld_res.data_size   = '0;
		ld_res.key_hash    = key_q;
		unique case (state_q)
			BK_IDLE: begin
				pop             = start;
				ld_res.key_hash = q_head;
				if (start && is_empty) begin
					ld            = 1'b1;
					ld_res.status = ST_EMPTY;
				end else if (start && idx_oob) begin
					ld            = 1'b1;
					ld_res.status = ST_INDEX_OOB;
				end
			end
			BK_SCAN: begin
				if (hit) begin
					ld              = 1'b1;
					ld_res.hit_slot = SLOT_W'(idx_s1);
					if (data_oob) begin
						ld_res.status = ST_DATA_OOB;
					end else begin
						ld_res.status      = ST_FOUND;
						ld_res.data_offset = ent.offset;
						ld_res.data_size   = ent.size;
					end
				end else if (last) begin
					ld = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ra_q        <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				ra_q <= '0;
			end else if (issue) begin
				ra_q <= ra_q + CNT_W'(1);
			end
			vld_s1 <= issue && !hit && !last;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= q_head;
		end
		idx_s1 <= ra_q[IDX_W-1:0];
		if (ld) begin
			result_q <= ld_res;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// File: bench/fkil_checker.sv
`timescale 1ns / 1ps
// Checker for the keyed index lookup block: watches the request, result and APB channels.
// It predicts every lookup result and compares it. Depends on fkil_pkg.
module fkil_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [fkil_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [fkil_pkg::CMD_W-1:0]     s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [fkil_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [fkil_pkg::STATUS_W-1:0]  m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output int                             mismatches,
	output int                             outstanding
);
	import fkil_pkg::*;

	// Shadow copy of the block state
	logic [WORD_W-1:0] hash_acc;
	entry_t            slots [MAX_ENTRIES];
	cfg_t              regs;
	result_t           due_results [$];
	result_t           want;
	result_t           got;
	logic [WORD_W-1:0] key;
	int                fails;

	function automatic logic [WORD_W-1:0] fnv_fold(input logic [WORD_W-1:0] h,
			input logic [WORD_W-1:0] v);
		return (h ^ v) * FNV_PRIME;
	endfunction

	// Resolve one lookup against the current registers and index
	function automatic result_t resolve_lookup(input logic [WORD_W-1:0] k);
		result_t   r;
		logic [33:0] idx_end;
		logic [32:0] data_end;
		int        n;
		bit        done;
		r = '0;
		r.key_hash = k;
		r.status = ST_MISS;
		done = 1'b0;
		idx_end = 34'(regs.index_start) + 34'(regs.entry_count) * 34'(ENTRY_BYTES);
		if (!regs.store_valid || regs.entry_count == '0) begin
			r.status = ST_EMPTY;
		end else if (idx_end > 34'(regs.store_bytes)) begin
			r.status = ST_INDEX_OOB;
		end else begin
			n = (regs.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(regs.entry_count);
			for (int i = 0; i < n && !done; i++) begin
				if (slots[i].hash == k) begin
					done = 1'b1;
					r.hit_slot = SLOT_W'(i);
					data_end = 33'(slots[i].offset) + 33'(slots[i].size);
					if (data_end > 33'(regs.store_bytes)) begin
						r.status = ST_DATA_OOB;
					end else begin
						r.status = ST_FOUND;
						r.data_offset = slots[i].offset;
						r.data_size = slots[i].size;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc = FNV_BASIS;
			regs = '0;
			due_results.delete();
			fails = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Compare an accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, expected none actual status %h data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = due_results.pop_front();
					got.status = status_t'(m_tuser);
					got.hit_slot = m_tdata[5:0];
					got.data_offset = m_tdata[37:6];
					got.data_size = m_tdata[69:38];
					got.key_hash = m_tdata[101:70];
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("hit_slot", 32'(want.hit_slot), 32'(got.hit_slot));
					check_field("data_offset", want.data_offset, got.data_offset);
					check_field("data_size", want.data_size, got.data_size);
					check_field("key_hash", want.key_hash, got.key_hash);
				end
			end

			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_STORE_VALID: regs.store_valid = pwdata[0];
					REG_ENTRY_COUNT: regs.entry_count = pwdata[ECNT_W-1:0];
					REG_INDEX_START: regs.index_start = pwdata;
					REG_STORE_BYTES: regs.store_bytes = pwdata;
					default: ;
				endcase
			end

			// Apply an accepted request
			if (s_tvalid && s_tready) begin
				case (cmd_t'(s_tuser))
					CMD_WRITE: begin
						slots[s_tdata[5:0]].hash = s_tdata[37:6];
						slots[s_tdata[5:0]].offset = s_tdata[69:38];
						slots[s_tdata[5:0]].size = s_tdata[101:70];
					end
					CMD_KEY: hash_acc = fnv_fold(hash_acc, 32'(s_tdata[109:102]));
					CMD_LOOKUP: begin
						key = fnv_fold(hash_acc, s_tdata[141:110]);
						due_results.push_back(resolve_lookup(key));
						hash_acc = FNV_BASIS;
					end
					default: ;
				endcase
			end

			mismatches <= fails;
			outstanding <= due_results.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the keyed index lookup testbench: clock, reset, request and APB stimulus, result sink.
// Depends on fkil_pkg, fnv_keyed_index_lookup and fkil_checker.
module tb;
	import fkil_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [3:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	int                   mismatches;
	int                   outstanding;

	int          cycles = 0;
	int          sent = 0;
	int          src_calm = 0;
	int          sink_calm = 0;
	bit          hold_req = 1'b0;
	logic [6:0]  cur_count = '0;
	logic [31:0] cur_bytes = '0;
	logic [7:0]  key_q [$];
	logic [31:0] key_method;

	fnv_keyed_index_lookup dut (.*);
	fkil_checker chk (.*);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Idle cycles before the next request or result, with calm stretches of none
	function automatic int draw_gap(input bit sink);
		int gap;
		int calm;
		calm = sink ? sink_calm : src_calm;
		if (calm == 0 && $urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
		if (calm > 0) begin
			calm = calm - 1;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 10);
		end
		if (sink) sink_calm = calm;
		else src_calm = calm;
		return gap;
	endfunction

	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
		return (h ^ v) * FNV_PRIME;
	endfunction

	function automatic logic [31:0] key_digest();
		logic [31:0] h;
		h = FNV_BASIS;
		foreach (key_q[i]) h = fnv_mix(h, 32'(key_q[i]));
		return fnv_mix(h, key_method);
	endfunction

	function automatic logic [S_TDATA_W-1:0] pack_request(input logic [SLOT_W-1:0] slot,
			input logic [31:0] h, input logic [31:0] off, input logic [31:0] sz,
			input logic [7:0] kb, input logic [31:0] method);
		return {2'b00, method, kb, sz, off, h, slot};
	endfunction

	// Offer one request and hold it until accepted
	task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] data);
		int gap;
		gap = draw_gap(1'b0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd != CMD_SPARE) sent++;
	endtask

	task automatic put_entry(input logic [SLOT_W-1:0] slot, input logic [31:0] h,
			input logic [31:0] off, input logic [31:0] sz);
		push_request(CMD_WRITE, pack_request(slot, h, off, sz, 8'($urandom), $urandom));
	endtask

	task automatic feed_byte(input logic [7:0] b);
		push_request(CMD_KEY, pack_request(6'($urandom), $urandom, $urandom, $urandom, b,
			$urandom));
	endtask

	task automatic push_spare();
		push_request(CMD_SPARE, pack_request(6'($urandom), $urandom, $urandom, $urandom,
			8'($urandom), $urandom));
	endtask

	// Send the current key bytes, then close the key with its method
	task automatic send_key();
		foreach (key_q[i]) feed_byte(key_q[i]);
		push_request(CMD_LOOKUP, pack_request(6'($urandom), $urandom, $urandom, $urandom,
			8'($urandom), key_method));
	endtask

	task automatic new_key();
		int len;
		key_q.delete();
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 4);
		repeat (len) key_q.push_back(8'($urandom));
		case ($urandom_range(0, 7))
			0: key_method = '0;
			1: key_method = '1;
			default: key_method = $urandom;
		endcase
	endtask

	// Setup and access phases, then a pause with the bus released
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] valid, input logic [31:0] count,
			input logic [31:0] base, input logic [31:0] bytes);
		apb_write(REG_STORE_VALID, valid);
		apb_write(REG_ENTRY_COUNT, count);
		apb_write(REG_INDEX_START, base);
		apb_write(REG_STORE_BYTES, bytes);
		cur_count = count[6:0];
		cur_bytes = bytes;
	endtask

	// Stop offering and wait until every lookup has answered
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One lookup, mostly with a matching entry planted first
	task automatic random_lookup();
		int          reach;
		int          s1;
		int          s2;
		int          pick;
		logic [31:0] h;
		logic [31:0] off;
		logic [31:0] sz;
		reach = (cur_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(cur_count);
		if ($urandom_range(0, 4) != 0) new_key();
		h = key_digest();
		pick = $urandom_range(0, 9);
		if (reach > 0 && pick < 6) begin
			if (pick == 0) begin
				// data runs past the end of the store
				if (cur_bytes == '1) begin
					off = '1;
					sz = $urandom_range(1, 32'hFFFF_FFFF);
				end else begin
					off = $urandom_range(0, cur_bytes);
					sz = cur_bytes - off + 1;
				end
			end else begin
				off = $urandom_range(0, cur_bytes);
				sz = $urandom_range(0, cur_bytes - off);
			end
			s1 = $urandom_range(0, reach - 1);
			put_entry(SLOT_W'(s1), h, off, sz);
			// a later duplicate must never win
			if (pick == 1 && s1 + 1 < reach) begin
				s2 = $urandom_range(s1 + 1, reach - 1);
				put_entry(SLOT_W'(s2), h, $urandom, $urandom);
			end
		end else if (pick == 7) begin
			put_entry(6'($urandom), $urandom, $urandom, $urandom);
		end else if (pick == 8) begin
			push_spare();
		end
		// stray byte: the key no longer matches what was planted
		if (pick == 9) feed_byte(8'($urandom));
		send_key();
	endtask

	// Result sink with random stalls and one long hold-off
	initial begin : sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(1'b1);
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int goal;
		logic [31:0] cnt;
		logic [31:0] base;
		logic [31:0] bytes;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups on an unloaded store, before any entry exists
		key_q.delete();
		key_method = '0;
		send_key();
		key_q.push_back(8'h00);
		key_q.push_back(8'hFF);
		key_method = '1;
		send_key();

		// Load every slot so no scan ever reads an unwritten entry
		put_entry(0, '0, '0, '0);
		for (int i = 1; i < MAX_ENTRIES - 1; i++) begin
			put_entry(SLOT_W'(i), $urandom, $urandom, $urandom);
		end
		put_entry(SLOT_W'(MAX_ENTRIES - 1), '1, '1, '1);

		// Small store whose index fills it exactly
		wait_idle();
		set_regs(1, 4, 0, 64);
		new_key();
		put_entry(2, key_digest(), 10, 54);
		send_key();
		new_key();
		put_entry(1, key_digest(), 10, 55);
		send_key();
		new_key();
		put_entry(3, key_digest(), 20, 4);
		put_entry(0, key_digest(), 30, 5);
		send_key();
		new_key();
		put_entry(5, key_digest(), 0, 1);
		send_key();
		push_spare();

		// Index region one byte past the store
		wait_idle();
		set_regs(1, 4, 1, 64);
		new_key();
		send_key();

		// All-ones writes: count above capacity, scan stops at the last slot
		wait_idle();
		set_regs('1, '1, 0, '1);
		new_key();
		put_entry(SLOT_W'(MAX_ENTRIES - 1), key_digest(), '1, 0);
		send_key();
		new_key();
		put_entry(SLOT_W'(MAX_ENTRIES - 2), key_digest(), '1, 1);
		send_key();

		// Random phases, each under its own register setting
		for (int p = 0; p < 9; p++) begin
			wait_idle();
			goal = 140;
			case (p)
				0: set_regs(1, MAX_ENTRIES, 0, '1);
				1: begin
					cnt = $urandom_range(1, MAX_ENTRIES);
					base = $urandom_range(0, 4096);
					bytes = $urandom_range(base + cnt * ENTRY_BYTES, 32'hFFFF_FFFF);
					set_regs(1, cnt, base, bytes);
				end
				2: set_regs(1, 1, 0, ENTRY_BYTES);
				3: set_regs(1, 127, 0, '1);
				4: set_regs(1, $urandom_range(1, 127), $urandom, $urandom);
				5: begin
					set_regs(0, $urandom_range(1, 127), 0, '1);
					goal = 40;
				end
				6: begin
					set_regs(1, 0, 0, 0);
					goal = 40;
				end
				7: begin
					set_regs(1, $urandom_range(1, MAX_ENTRIES), '1, '1);
					goal = 40;
				end
				default: set_regs(1, 2, 0, $urandom_range(32, 4000));
			endcase
			if (p == 0) hold_req = 1'b1;
			goal = sent + goal;
			while (sent < goal) random_lookup();
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
